[hdl/udpck_pkg.sv]
// udpck_pkg: shared types for the UDP/IPv4 transmit checksum and length block.
// Used by udpck_front, udpck_back and udp_ip_tx_checksum_length. No dependencies.
`default_nettype none
package udpck_pkg;

	localparam int DATA_W = 64;
	localparam int KEEP_W = 8;
	localparam int IP_W   = 32;
	localparam int PORT_W = 16;
	localparam int MAC_W  = 48;
	localparam int LEN_W  = 16;
	localparam int PSUM_W = 32;
	localparam int FSUM_W = 17;
	localparam int IPS_W  = 19;
	localparam int CHK_W  = 16;
	localparam int UDPS_W = 17;

	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	typedef enum logic [1:0] {
		REG_OWN_IP    = 2'd0,
		REG_IP_FIXED  = 2'd1,
		REG_UDP_FIXED = 2'd2,
		REG_NONE      = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [IP_W-1:0]   own_ip;
		logic [FSUM_W-1:0] ip_fixed_sum;
		logic [FSUM_W-1:0] udp_fixed_sum;
	} cfg_t;

	// front -> back queue entry: beat plus packet totals and header
	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic [KEEP_W-1:0] keep;
		logic              last;
		logic [PSUM_W-1:0] psum;
		logic [LEN_W-1:0]  len;
		logic [IP_W-1:0]   ip;
		logic [PORT_W-1:0] sport;
		logic [PORT_W-1:0] dport;
		logic [MAC_W-1:0]  mac;
	} entry_t;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic [KEEP_W-1:0] keep;
		logic              last;
		logic              header_valid;
		logic [MAC_W-1:0]  mac;
		logic [IP_W-1:0]   ip;
		logic [PORT_W-1:0] sport;
		logic [PORT_W-1:0] dport;
		logic [CHK_W-1:0]  ip_checksum;
		logic [UDPS_W-1:0] udp_sum;
		logic [LEN_W-1:0]  len;
	} result_t;

endpackage
`default_nettype wire

[hdl/udpck_fifo.sv]
// udpck_fifo: small register queue, first in first out.
// Generic; no package dependency.
`default_nettype none
module udpck_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

[hdl/udpck_front.sv]
// udpck_front: accepts beats, captures the header on a packet's first beat,
// accumulates payload sum and length. Depends on udpck_pkg.
`default_nettype none
module udpck_front #(
	parameter int BEAT_WORDS = 4
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        accept,
	input  wire logic [udpck_pkg::DATA_W-1:0] beat_data,
	input  wire logic [udpck_pkg::KEEP_W-1:0] beat_keep,
	input  wire logic                        beat_last,
	input  wire logic [udpck_pkg::IP_W-1:0]   target_ip,
	input  wire logic [udpck_pkg::PORT_W-1:0] source_port,
	input  wire logic [udpck_pkg::PORT_W-1:0] target_port,
	input  wire logic [udpck_pkg::MAC_W-1:0]  target_mac,
	output udpck_pkg::entry_t                entry
);
	import udpck_pkg::*;

	localparam int BSUM_W = 16 + $clog2(BEAT_WORDS + 1);
	localparam int BLEN_W = $clog2(2 * BEAT_WORDS + 1);

	logic [PSUM_W-1:0] psum_q;
	logic [LEN_W-1:0]  len_q;
	logic              in_pkt_q;
	logic [IP_W-1:0]   ip_q;
	logic [PORT_W-1:0] sport_q;
	logic [PORT_W-1:0] dport_q;
	logic [MAC_W-1:0]  mac_q;

	logic [BSUM_W-1:0] beat_sum;
	logic [BLEN_W-1:0] beat_len;
	logic [PSUM_W-1:0] psum_tot;
	logic [LEN_W-1:0]  len_tot;

	always_comb begin
		beat_sum = '0;
		beat_len = '0;
		for (int w = 0; w < BEAT_WORDS; w++) begin
			beat_sum = beat_sum + BSUM_W'({
				beat_keep[2*w+1] ? beat_data[16*w+8 +: 8] : 8'h00,
				beat_keep[2*w]   ? beat_data[16*w +: 8]   : 8'h00});
			beat_len = beat_len + BLEN_W'(beat_keep[2*w]) + BLEN_W'(beat_keep[2*w+1]);
		end
	end

	assign psum_tot = psum_q + PSUM_W'(beat_sum);
	assign len_tot  = len_q + LEN_W'(beat_len);

	always_comb begin
		entry.data  = beat_data;
		entry.keep  = beat_keep;
		entry.last  = beat_last;
		entry.psum  = psum_tot;
		entry.len   = len_tot;
		entry.ip    = in_pkt_q ? ip_q    : target_ip;
		entry.sport = in_pkt_q ? sport_q : source_port;
		entry.dport = in_pkt_q ? dport_q : target_port;
		entry.mac   = in_pkt_q ? mac_q   : target_mac;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psum_q   <= '0;
			len_q    <= '0;
			in_pkt_q <= 1'b0;
			ip_q     <= '0;
			sport_q  <= '0;
			dport_q  <= '0;
			mac_q    <= '0;
		end else if (accept) begin
			if (!in_pkt_q) begin
				ip_q    <= target_ip;
				sport_q <= source_port;
				dport_q <= target_port;
				mac_q   <= target_mac;
			end
			if (beat_last) begin
				psum_q   <= '0;
				len_q    <= '0;
				in_pkt_q <= 1'b0;
			end else begin
				psum_q   <= psum_tot;
				len_q    <= len_tot;
				in_pkt_q <= 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

[hdl/udpck_back.sv]
// udpck_back: takes queued beats, sums the IPv4 and UDP checksum terms in one
// stage, folds and forms the result item. Depends on udpck_pkg.
`default_nettype none
module udpck_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire udpck_pkg::cfg_t   cfg,
	input  wire logic              q_empty,
	input  wire udpck_pkg::entry_t q_entry,
	output logic                   q_pop,
	input  wire logic              o_full,
	output logic                   o_push,
	output udpck_pkg::result_t     o_result
);
	import udpck_pkg::*;

	logic              v_s1;
	entry_t            e_s1;
	logic [IPS_W-1:0]  ip_s_s1;
	logic [PSUM_W-1:0] udp_s_s1;

	logic              advance;
	logic [IPS_W-1:0]  ip_s;
	logic [PSUM_W-1:0] udp_s;
	logic [FSUM_W-1:0] ip_f;
	logic [UDPS_W-1:0] udp_f;

	assign advance = !v_s1 || !o_full;
	assign q_pop   = !q_empty && advance;
	assign o_push  = v_s1 && !o_full;

	always_comb begin
		ip_s = IPS_W'(cfg.ip_fixed_sum) + IPS_W'(cfg.own_ip[31:16])
			+ IPS_W'(cfg.own_ip[15:0]) + IPS_W'(q_entry.ip[31:16])
			+ IPS_W'(q_entry.ip[15:0]) + IPS_W'(q_entry.len);
		udp_s = PSUM_W'(cfg.udp_fixed_sum) + PSUM_W'(cfg.own_ip[31:16])
			+ PSUM_W'(cfg.own_ip[15:0]) + PSUM_W'(q_entry.ip[31:16])
			+ PSUM_W'(q_entry.ip[15:0]) + PSUM_W'(q_entry.sport)
			+ PSUM_W'(q_entry.dport) + PSUM_W'({q_entry.len, 1'b0})
			+ q_entry.psum;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			e_s1     <= q_entry;
			ip_s_s1  <= ip_s;
			udp_s_s1 <= udp_s;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (advance) begin
			v_s1 <= !q_empty;
		end
	end

	assign ip_f  = FSUM_W'(ip_s_s1[IPS_W-1:16]) + FSUM_W'(ip_s_s1[15:0]);
	assign udp_f = UDPS_W'(udp_s_s1[31:16]) + UDPS_W'(udp_s_s1[15:0]);

	always_comb begin
		o_result.data         = e_s1.data;
		o_result.keep         = e_s1.keep;
		o_result.last         = e_s1.last;
		o_result.header_valid = e_s1.last;
		o_result.mac          = e_s1.last ? e_s1.mac    : '0;
		o_result.ip           = e_s1.last ? e_s1.ip     : '0;
		o_result.sport        = e_s1.last ? e_s1.sport  : '0;
		o_result.dport        = e_s1.last ? e_s1.dport  : '0;
		o_result.ip_checksum  = e_s1.last ? ~ip_f[15:0] : '0;
		o_result.udp_sum      = e_s1.last ? udp_f       : '0;
		o_result.len          = e_s1.last ? e_s1.len    : '0;
	end
endmodule
`default_nettype wire

[hdl/udp_ip_tx_checksum_length.sv]
// udp_ip_tx_checksum_length: top level with APB registers, front, queues, back.
// Depends on udpck_pkg, udpck_front, udpck_fifo, udpck_back.
//
// Usage: beats enter on a queue-style port (push/full) and leave unchanged on
// a queue-style result port (empty/pop), one result item per beat. On the last
// beat of a packet the result also carries the header captured on the first
// beat, the inverted IPv4 header checksum, the folded UDP sum and the length.
// Throughput: one beat per clock while full is low; the front accumulates one
// beat each cycle and the back checksum stage takes one entry per cycle unless the output queue is full.
// An item pushed passes through the front queue, the checksum stage and the
// output queue, in that order, on its way to the result ports.
// When the receiver stops popping, the output queue, the checksum stage and
// the front queue fill in turn and full rises; nothing is lost.
// Reset clears the accumulators, the packet state, the queues and registers.
// Registers (APB, byte address): 0x0 own_ip, 0x4 ip_fixed_sum,
// 0x8 udp_fixed_sum; write them only while no beat is in flight.
`default_nettype none
module udp_ip_tx_checksum_length #(
	parameter int BEAT_WORDS = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [udpck_pkg::APB_AW-1:0]  paddr,
	input  wire logic [udpck_pkg::APB_DW-1:0]  pwdata,
	output logic [udpck_pkg::APB_DW-1:0]       prdata,
	output logic                               pready,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [udpck_pkg::DATA_W-1:0]  beat_data,
	input  wire logic [udpck_pkg::KEEP_W-1:0]  beat_keep,
	input  wire logic                          beat_last,
	input  wire logic [udpck_pkg::IP_W-1:0]    target_ip,
	input  wire logic [udpck_pkg::PORT_W-1:0]  source_port,
	input  wire logic [udpck_pkg::PORT_W-1:0]  target_port,
	input  wire logic [udpck_pkg::MAC_W-1:0]   target_mac,
	output logic                               empty,
	input  wire logic                          pop,
	output logic [udpck_pkg::DATA_W-1:0]       out_data,
	output logic [udpck_pkg::KEEP_W-1:0]       out_keep,
	output logic                               out_last,
	output logic                               header_valid,
	output logic [udpck_pkg::MAC_W-1:0]        hdr_mac,
	output logic [udpck_pkg::IP_W-1:0]         hdr_ip,
	output logic [udpck_pkg::PORT_W-1:0]       hdr_sport,
	output logic [udpck_pkg::PORT_W-1:0]       hdr_dport,
	output logic [udpck_pkg::CHK_W-1:0]        ip_checksum,
	output logic [udpck_pkg::UDPS_W-1:0]       udp_sum,
	output logic [udpck_pkg::LEN_W-1:0]        pkt_len
);
	import udpck_pkg::*;

	localparam int QDEPTH = 2;

	cfg_t     cfg_q;
	reg_idx_t widx;
	logic     cfg_wr;

	entry_t   f_entry;
	entry_t   q_entry;
	logic     q_full;
	logic     q_empty;
	logic     q_pop;
	logic     accept;
	logic     o_full;
	logic     o_push;
	result_t  b_result;
	result_t  o_result;

	// APB registers
	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[3:2]);
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			unique case (widx)
				REG_OWN_IP:    cfg_q.own_ip        <= pwdata;
				REG_IP_FIXED:  cfg_q.ip_fixed_sum  <= pwdata[FSUM_W-1:0];
				REG_UDP_FIXED: cfg_q.udp_fixed_sum <= pwdata[FSUM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (widx)
			REG_OWN_IP:    prdata = cfg_q.own_ip;
			REG_IP_FIXED:  prdata = APB_DW'(cfg_q.ip_fixed_sum);
			REG_UDP_FIXED: prdata = APB_DW'(cfg_q.udp_fixed_sum);
			default:       prdata = '0;
		endcase
	end

	assign full   = q_full;
	assign accept = push && !q_full;

	udpck_front #(
		.BEAT_WORDS(BEAT_WORDS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.beat_data   (beat_data),
		.beat_keep   (beat_keep),
		.beat_last   (beat_last),
		.target_ip   (target_ip),
		.source_port (source_port),
		.target_port (target_port),
		.target_mac  (target_mac),
		.entry       (f_entry)
	);

	udpck_fifo #(
		.WIDTH($bits(entry_t)),
		.DEPTH(QDEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (f_entry),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_entry),
		.empty   (q_empty)
	);

	udpck_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_entry  (q_entry),
		.q_pop    (q_pop),
		.o_full   (o_full),
		.o_push   (o_push),
		.o_result (b_result)
	);

	udpck_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(QDEPTH)
	) u_out_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (o_push),
		.wr_data (b_result),
		.full    (o_full),
		.rd_en   (pop),
		.rd_data (o_result),
		.empty   (empty)
	);

	assign out_data     = o_result.data;
	assign out_keep     = o_result.keep;
	assign out_last     = o_result.last;
	assign header_valid = o_result.header_valid;
	assign hdr_mac      = o_result.mac;
	assign hdr_ip       = o_result.ip;
	assign hdr_sport    = o_result.sport;
	assign hdr_dport    = o_result.dport;
	assign ip_checksum  = o_result.ip_checksum;
	assign udp_sum      = o_result.udp_sum;
	assign pkt_len      = o_result.len;
endmodule
`default_nettype wire
